// ===== sv/dpw_pkg.sv =====
// ----------------------------------------------------------------------------
// dpw_pkg
// Types and constants shared by the depth pixel to world point pipeline.
// ----------------------------------------------------------------------------
package dpw_pkg;

	localparam int COL_W    = 12;
	localparam int DEPTH_W  = 16;
	localparam int COLOR_W  = 8;
	localparam int IFOC_W   = 32;
	localparam int ROT_W    = 48;
	localparam int COEF_W   = 16;
	localparam int TCOMP_W  = 21;
	localparam int TRANS_W  = 63;
	localparam int IDX_W    = 3;
	localparam int CFG_W    = 63;

	localparam int DU_W     = COL_W + 1;
	localparam int DP_W     = DEPTH_W + 1 + DU_W;
	localparam int CP_W     = DP_W + IFOC_W;
	localparam int CAM_SH   = 24;
	localparam int PXY_W    = CP_W - CAM_SH;
	localparam int PZ_W     = DEPTH_W + 5;
	localparam int RP_W     = COEF_W + PXY_W;
	localparam int SUM_W    = RP_W + 2;
	localparam int ROT_SH   = 14;
	localparam int RS_W     = SUM_W - ROT_SH;
	localparam int WS_W     = RS_W + 1;
	localparam int WORLD_W  = 28;

	localparam logic [WORLD_W-1:0] WORLD_MAX = {1'b0, {(WORLD_W-1){1'b1}}};
	localparam logic [WORLD_W-1:0] WORLD_MIN = {1'b1, {(WORLD_W-1){1'b0}}};

	typedef enum logic [IDX_W-1:0] {
		REG_INV_FOCAL_X = 3'd0,
		REG_INV_FOCAL_Y = 3'd1,
		REG_CENTER_X    = 3'd2,
		REG_CENTER_Y    = 3'd3,
		REG_ROT_ROW0    = 3'd4,
		REG_ROT_ROW1    = 3'd5,
		REG_ROT_ROW2    = 3'd6,
		REG_TRANSLATION = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [IFOC_W-1:0]  inv_focal_x;
		logic [IFOC_W-1:0]  inv_focal_y;
		logic [COL_W-1:0]   center_x;
		logic [COL_W-1:0]   center_y;
		logic [ROT_W-1:0]   rot_row0;
		logic [ROT_W-1:0]   rot_row1;
		logic [ROT_W-1:0]   rot_row2;
		logic [TRANS_W-1:0] translation;
	} cfg_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               frame_end;
	} side_t;

endpackage

// ===== sv/depth_pixel_to_world_point.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point
// Back-projects a depth pixel through a pinhole model and moves the point
// into the world frame with a configured rotation and translation.
// ----------------------------------------------------------------------------
// an accepted item passes through seven register stages s1..s7
// before out_valid rises
// throughput: one item per cycle while out_stall is low; every stage
// s1..s7 can advance each cycle; a stall holds full stages, empty ones fill
// reset clears all stage valid bits and all configuration registers to zero
module depth_pixel_to_world_point #(
	parameter int MAX_IMAGE_SIDE = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dpw_pkg::IDX_W-1:0]           cfg_index,
	input  logic [dpw_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [dpw_pkg::COL_W-1:0]           pixel_col,
	input  logic [dpw_pkg::COL_W-1:0]           pixel_row,
	input  logic [dpw_pkg::DEPTH_W-1:0]         depth_mm,
	input  logic [dpw_pkg::COLOR_W-1:0]         in_red,
	input  logic [dpw_pkg::COLOR_W-1:0]         in_green,
	input  logic [dpw_pkg::COLOR_W-1:0]         in_blue,
	input  logic                                in_frame_end,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [dpw_pkg::WORLD_W-1:0]  world_x,
	output logic signed [dpw_pkg::WORLD_W-1:0]  world_y,
	output logic signed [dpw_pkg::WORLD_W-1:0]  world_z,
	output logic [dpw_pkg::COLOR_W-1:0]         out_red,
	output logic [dpw_pkg::COLOR_W-1:0]         out_green,
	output logic [dpw_pkg::COLOR_W-1:0]         out_blue,
	output logic                                out_frame_end
);

	dpw_pkg::cfg_t  cfg;
	dpw_pkg::side_t in_side, cam_side, out_side;

	logic                              cam_valid, cam_stall;
	logic signed [dpw_pkg::PXY_W-1:0]  cam_px, cam_py;
	logic signed [dpw_pkg::PZ_W-1:0]   cam_pz;
	logic [dpw_pkg::WORLD_W-1:0]       world [3];

	assign in_side.red       = in_red;
	assign in_side.green     = in_green;
	assign in_side.blue      = in_blue;
	assign in_side.frame_end = in_frame_end;

	dpw_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dpw_cam #(
		.MAX_IMAGE_SIDE (MAX_IMAGE_SIDE)
	) u_cam (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_col (pixel_col),
		.pixel_row (pixel_row),
		.depth_mm  (depth_mm),
		.in_side   (in_side),
		.cam_valid (cam_valid),
		.cam_stall (cam_stall),
		.cam_px    (cam_px),
		.cam_py    (cam_py),
		.cam_pz    (cam_pz),
		.cam_side  (cam_side)
	);

	dpw_xform u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cam_valid (cam_valid),
		.cam_stall (cam_stall),
		.cam_px    (cam_px),
		.cam_py    (cam_py),
		.cam_pz    (cam_pz),
		.cam_side  (cam_side),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.world     (world),
		.out_side  (out_side)
	);

	assign world_x       = world[0];
	assign world_y       = world[1];
	assign world_z       = world[2];
	assign out_red       = out_side.red;
	assign out_green     = out_side.green;
	assign out_blue      = out_side.blue;
	assign out_frame_end = out_side.frame_end;

endmodule

// ===== sv/dpw_regs.sv =====
// ----------------------------------------------------------------------------
// dpw_regs
// Configuration register file: intrinsics, rotation rows and translation.
// ----------------------------------------------------------------------------
module dpw_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [dpw_pkg::IDX_W-1:0] cfg_index,
	input  logic [dpw_pkg::CFG_W-1:0] cfg_data,
	output dpw_pkg::cfg_t             cfg
);

	dpw_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (dpw_pkg::reg_idx_t'(cfg_index))
				dpw_pkg::REG_INV_FOCAL_X: begin
					cfg_q.inv_focal_x <= cfg_data[dpw_pkg::IFOC_W-1:0];
				end
				dpw_pkg::REG_INV_FOCAL_Y: begin
					cfg_q.inv_focal_y <= cfg_data[dpw_pkg::IFOC_W-1:0];
				end
				dpw_pkg::REG_CENTER_X: begin
					cfg_q.center_x <= cfg_data[dpw_pkg::COL_W-1:0];
				end
				dpw_pkg::REG_CENTER_Y: begin
					cfg_q.center_y <= cfg_data[dpw_pkg::COL_W-1:0];
				end
				dpw_pkg::REG_ROT_ROW0: begin
					cfg_q.rot_row0 <= cfg_data[dpw_pkg::ROT_W-1:0];
				end
				dpw_pkg::REG_ROT_ROW1: begin
					cfg_q.rot_row1 <= cfg_data[dpw_pkg::ROT_W-1:0];
				end
				dpw_pkg::REG_ROT_ROW2: begin
					cfg_q.rot_row2 <= cfg_data[dpw_pkg::ROT_W-1:0];
				end
				dpw_pkg::REG_TRANSLATION: begin
					cfg_q.translation <= cfg_data[dpw_pkg::TRANS_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/dpw_cam.sv =====
// ----------------------------------------------------------------------------
// dpw_cam
// Back-projection stages s1..s4: clamp and center, depth product, inverse
// focal product, rounding to 1/16 mm camera coordinates.
// ----------------------------------------------------------------------------
module dpw_cam #(
	parameter int MAX_IMAGE_SIDE = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dpw_pkg::cfg_t                      cfg,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [dpw_pkg::COL_W-1:0]          pixel_col,
	input  logic [dpw_pkg::COL_W-1:0]          pixel_row,
	input  logic [dpw_pkg::DEPTH_W-1:0]        depth_mm,
	input  dpw_pkg::side_t                     in_side,
	output logic                               cam_valid,
	input  logic                               cam_stall,
	output logic signed [dpw_pkg::PXY_W-1:0]   cam_px,
	output logic signed [dpw_pkg::PXY_W-1:0]   cam_py,
	output logic signed [dpw_pkg::PZ_W-1:0]    cam_pz,
	output dpw_pkg::side_t                     cam_side
);

	localparam int CMP_W = 18;
	localparam logic [CMP_W-1:0] SIDE_LIM = CMP_W'(MAX_IMAGE_SIDE);
	localparam logic [dpw_pkg::COL_W-1:0] SIDE_TOP = dpw_pkg::COL_W'(MAX_IMAGE_SIDE - 1);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic [dpw_pkg::COL_W-1:0] u_cl, v_cl;

	logic signed [dpw_pkg::DU_W-1:0]    du_s1, dv_s1;
	logic [dpw_pkg::DEPTH_W-1:0]        d_s1, d_s2, d_s3;
	dpw_pkg::side_t                     side_s1, side_s2, side_s3, side_s4;
	logic signed [dpw_pkg::DP_W-1:0]    dpx_s2, dpy_s2;
	logic signed [dpw_pkg::CP_W-1:0]    cpx_s3, cpy_s3;
	logic signed [dpw_pkg::PXY_W-1:0]   px_s4, py_s4;
	logic signed [dpw_pkg::PZ_W-1:0]    pz_s4;

	logic signed [dpw_pkg::DP_W-1:0]    d_ext, du_ext, dv_ext;
	logic signed [dpw_pkg::CP_W-1:0]    dpx_ext, dpy_ext, ifx_ext, ify_ext;
	logic signed [dpw_pkg::CP_W:0]      rx, ry;

	assign rdy_s4 = !v_s4 || !cam_stall;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_comb begin
		u_cl = (CMP_W'(pixel_col) >= SIDE_LIM) ? SIDE_TOP : pixel_col;
		v_cl = (CMP_W'(pixel_row) >= SIDE_LIM) ? SIDE_TOP : pixel_row;
		d_ext   = $signed(dpw_pkg::DP_W'(d_s1));
		du_ext  = dpw_pkg::DP_W'(du_s1);
		dv_ext  = dpw_pkg::DP_W'(dv_s1);
		dpx_ext = dpw_pkg::CP_W'(dpx_s2);
		dpy_ext = dpw_pkg::CP_W'(dpy_s2);
		ifx_ext = $signed(dpw_pkg::CP_W'(cfg.inv_focal_x));
		ify_ext = $signed(dpw_pkg::CP_W'(cfg.inv_focal_y));
		// round half up then floor shift
		rx = (dpw_pkg::CP_W + 1)'(cpx_s3) + (dpw_pkg::CP_W + 1)'(1 << (dpw_pkg::CAM_SH - 1));
		ry = (dpw_pkg::CP_W + 1)'(cpy_s3) + (dpw_pkg::CP_W + 1)'(1 << (dpw_pkg::CAM_SH - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			du_s1   <= $signed({1'b0, u_cl}) - $signed({1'b0, cfg.center_x});
			dv_s1   <= $signed({1'b0, v_cl}) - $signed({1'b0, cfg.center_y});
			d_s1    <= depth_mm;
			side_s1 <= in_side;
		end
		if (rdy_s2 && v_s1) begin
			dpx_s2  <= d_ext * du_ext;
			dpy_s2  <= d_ext * dv_ext;
			d_s2    <= d_s1;
			side_s2 <= side_s1;
		end
		if (rdy_s3 && v_s2) begin
			cpx_s3  <= dpx_ext * ifx_ext;
			cpy_s3  <= dpy_ext * ify_ext;
			d_s3    <= d_s2;
			side_s3 <= side_s2;
		end
		if (rdy_s4 && v_s3) begin
			px_s4   <= rx[dpw_pkg::CP_W-1:dpw_pkg::CAM_SH];
			py_s4   <= ry[dpw_pkg::CP_W-1:dpw_pkg::CAM_SH];
			pz_s4   <= $signed({1'b0, d_s3, 4'b0000});
			side_s4 <= side_s3;
		end
	end

	assign cam_valid = v_s4;
	assign cam_px    = px_s4;
	assign cam_py    = py_s4;
	assign cam_pz    = pz_s4;
	assign cam_side  = side_s4;

endmodule

// ===== sv/dpw_xform.sv =====
// ----------------------------------------------------------------------------
// dpw_xform
// Rigid transform stages s5..s7: rotation products, row sums with rounding,
// translation add and saturation into the output register.
// ----------------------------------------------------------------------------
module dpw_xform (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dpw_pkg::cfg_t                      cfg,
	input  logic                               cam_valid,
	output logic                               cam_stall,
	input  logic signed [dpw_pkg::PXY_W-1:0]   cam_px,
	input  logic signed [dpw_pkg::PXY_W-1:0]   cam_py,
	input  logic signed [dpw_pkg::PZ_W-1:0]    cam_pz,
	input  dpw_pkg::side_t                     cam_side,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [dpw_pkg::WORLD_W-1:0]        world [3],
	output dpw_pkg::side_t                     out_side
);

	localparam int HI_W = dpw_pkg::WS_W - dpw_pkg::WORLD_W + 1;

	logic v_s5, v_s6, v_s7;
	logic rdy_s5, rdy_s6, rdy_s7;

	logic [dpw_pkg::ROT_W-1:0]           rot [3];
	logic signed [dpw_pkg::RP_W-1:0]     pe [3];
	logic signed [dpw_pkg::RP_W-1:0]     prod_s5 [3][3];
	logic signed [dpw_pkg::RS_W-1:0]     rs_s6 [3];
	logic [dpw_pkg::WORLD_W-1:0]         w_s7 [3];
	dpw_pkg::side_t                      side_s5, side_s6, side_s7;

	logic signed [dpw_pkg::SUM_W-1:0]    sum [3];
	logic signed [dpw_pkg::WS_W-1:0]     ws [3];
	logic [dpw_pkg::WORLD_W-1:0]         wsat [3];

	assign rdy_s7 = !v_s7 || !out_stall;
	assign rdy_s6 = !v_s6 || rdy_s7;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign cam_stall = !rdy_s5;

	assign rot[0] = cfg.rot_row0;
	assign rot[1] = cfg.rot_row1;
	assign rot[2] = cfg.rot_row2;
	assign pe[0]  = dpw_pkg::RP_W'(cam_px);
	assign pe[1]  = dpw_pkg::RP_W'(cam_py);
	assign pe[2]  = dpw_pkg::RP_W'(cam_pz);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = dpw_pkg::SUM_W'(prod_s5[i][0]) + dpw_pkg::SUM_W'(prod_s5[i][1])
				+ dpw_pkg::SUM_W'(prod_s5[i][2])
				+ dpw_pkg::SUM_W'(1 << (dpw_pkg::ROT_SH - 1));
			ws[i] = dpw_pkg::WS_W'(rs_s6[i])
				+ dpw_pkg::WS_W'($signed(cfg.translation[dpw_pkg::TCOMP_W*i +: dpw_pkg::TCOMP_W]));
			if (ws[i][dpw_pkg::WS_W-1:dpw_pkg::WORLD_W-1] == '0 ||
				ws[i][dpw_pkg::WS_W-1:dpw_pkg::WORLD_W-1] == {HI_W{1'b1}}) begin
				wsat[i] = ws[i][dpw_pkg::WORLD_W-1:0];
			end else if (ws[i][dpw_pkg::WS_W-1]) begin
				wsat[i] = dpw_pkg::WORLD_MIN;
			end else begin
				wsat[i] = dpw_pkg::WORLD_MAX;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy_s5) v_s5 <= cam_valid;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && cam_valid) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s5[i][k] <= dpw_pkg::RP_W'($signed(
						rot[i][dpw_pkg::COEF_W*k +: dpw_pkg::COEF_W])) * pe[k];
				end
			end
			side_s5 <= cam_side;
		end
		if (rdy_s6 && v_s5) begin
			for (int i = 0; i < 3; i++) begin
				rs_s6[i] <= sum[i][dpw_pkg::SUM_W-1:dpw_pkg::ROT_SH];
			end
			side_s6 <= side_s5;
		end
		if (rdy_s7 && v_s6) begin
			for (int i = 0; i < 3; i++) begin
				w_s7[i] <= wsat[i];
			end
			side_s7 <= side_s6;
		end
	end

	assign out_valid = v_s7;
	assign world     = w_s7;
	assign out_side  = side_s7;

endmodule

// ===== sv/dpw_chk.sv =====
// ----------------------------------------------------------------------------
// dpw_chk
// Port-level checks on the pipeline: occupancy bound, stall behavior and
// a held result under output stall.
// ----------------------------------------------------------------------------
module dpw_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [dpw_pkg::WORLD_W-1:0]       world_x,
	input logic [dpw_pkg::WORLD_W-1:0]       world_y,
	input logic [dpw_pkg::WORLD_W-1:0]       world_z
);

	localparam int DEPTH = 7;

	logic [3:0] fill_q;
	logic       acc_in, acc_out;

	assign acc_in  = in_valid && !in_stall;
	assign acc_out = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_q + 4'(acc_in) - 4'(acc_out);
		end
	end

	// items in flight never exceed the stage count
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 4'(DEPTH))
		else $error("more items in flight than pipeline stages");

	// a result is only shown for an item that was taken in
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fill_q != 4'd0)
		else $error("result without an accepted item");

	// input only stalls when the output is full and held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output can drain");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(world_x) &&
			$stable(world_y) && $stable(world_z))
		else $error("stalled result changed");

endmodule

bind depth_pixel_to_world_point dpw_chk u_chk (.*);
